// ===== hdl/scancode_event_queue_core_assert.svh =====
// assertion macros used by the checker file
`ifndef SCANCODE_EVENT_QUEUE_CORE_ASSERT_SVH
`define SCANCODE_EVENT_QUEUE_CORE_ASSERT_SVH

// checked only out of reset
`define SCEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define SCEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/sceq_pkg.sv =====
// types, constants and the letter table of the scancode event queue
package sceq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned PendW      = 5;

  localparam logic [7:0] PrefixE0 = 8'he0;
  localparam logic [7:0] PrefixE1 = 8'he1;

  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;

  typedef struct packed {
    logic [6:0] code;
    logic       pressed;
    logic [6:0] chr;
  } sceq_event_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } sceq_state_e;

  function automatic logic [6:0] sceq_letter(input logic [6:0] mk);
    logic [6:0] chr;
    chr = '0;
    case (mk)
      7'h10: chr = 7'("Q");
      7'h11: chr = 7'("W");
      7'h12: chr = 7'("E");
      7'h13: chr = 7'("R");
      7'h14: chr = 7'("T");
      7'h15: chr = 7'("Y");
      7'h16: chr = 7'("U");
      7'h17: chr = 7'("I");
      7'h18: chr = 7'("O");
      7'h19: chr = 7'("P");
      7'h1e: chr = 7'("A");
      7'h1f: chr = 7'("S");
      7'h20: chr = 7'("D");
      7'h21: chr = 7'("F");
      7'h22: chr = 7'("G");
      7'h23: chr = 7'("H");
      7'h24: chr = 7'("J");
      7'h25: chr = 7'("K");
      7'h26: chr = 7'("L");
      7'h2c: chr = 7'("Z");
      7'h2d: chr = 7'("X");
      7'h2e: chr = 7'("C");
      7'h2f: chr = 7'("V");
      7'h30: chr = 7'("B");
      7'h31: chr = 7'("N");
      7'h32: chr = 7'("M");
      7'h39: chr = 7'(" ");
      default: chr = '0;
    endcase
    return chr;
  endfunction

endpackage

// ===== hdl/sceq_if.sv =====
// valid/ready channel interfaces for scancode input and event output
interface sceq_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] raw_code;

  modport source (output valid, output cmd, output raw_code, input ready);
  modport sink (input valid, input cmd, input raw_code, output ready);
endinterface

interface sceq_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [6:0] event_code;
  logic       event_pressed;
  logic [6:0] event_char;
  logic [4:0] pending;

  modport source (
    output valid, output ok, output event_code, output event_pressed,
    output event_char, output pending, input ready
  );
  modport sink (
    input valid, input ok, input event_code, input event_pressed,
    input event_char, input pending, output ready
  );
endinterface

// ===== hdl/sceq_decoder.sv =====
// set-1 scancode decoder: make code, press flag, letter and prefix detect
module sceq_decoder
  import sceq_pkg::*;
(
  input  logic [7:0]  raw_code_i,
  output sceq_event_t event_o,
  output logic        prefix_o
);

  assign event_o.code    = raw_code_i[6:0];
  assign event_o.pressed = ~raw_code_i[7];
  assign event_o.chr     = sceq_letter(raw_code_i[6:0]);
  assign prefix_o        = (raw_code_i == PrefixE0) || (raw_code_i == PrefixE1);

endmodule

// ===== hdl/scancode_event_queue_core.sv =====
// scancode event queue top level: decoder, event memory and output register
//
//   channel | modport | payload
//   in_i    | sink    | cmd, raw_code
//   out_o   | source  | ok, event_code, event_pressed, event_char, pending
//
// push, prefix byte, full queue or empty pop: result registered in the cycle after acceptance
// pop of a stored event: the event memory's registered read, then the output register
// one transaction in flight; a new one is taken as the output register frees up
// reset clears pointers, fill count and control; the memory needs no clearing pass
// a stalled output holds its result and blocks further input
module scancode_event_queue_core
  import sceq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  sceq_in_if.sink           in_i,
  sceq_out_if.source        out_o
);

  sceq_event_t mem_q [QueueDepth];
  sceq_event_t rd_data_q;

  sceq_state_e         state_q, state_d;
  logic [PtrW-1:0]     head_q, head_d;
  logic [PtrW-1:0]     tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;

  logic                out_valid_q, out_valid_d;
  logic                ok_q, ok_d;
  sceq_event_t         res_q, res_d;
  logic [PendW-1:0]    pend_q, pend_d;

  sceq_event_t         dec_event;
  logic                dec_prefix;
  logic                accept, load, wr_en, rd_en;
  logic                full, empty;

  sceq_decoder u_decoder (
    .raw_code_i (in_i.raw_code),
    .event_o    (dec_event),
    .prefix_o   (dec_prefix)
  );

  assign full   = (count_q == CntW'(QueueDepth));
  assign empty  = (count_q == '0);
  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept = in_i.valid && in_i.ready;
  assign wr_en  = accept && (in_i.cmd == CmdPush) && !dec_prefix && !full;
  assign rd_en  = accept && (in_i.cmd == CmdPop) && !empty;

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    load    = 1'b0;
    ok_d    = ok_q;
    res_d   = res_q;
    pend_d  = pend_q;
    unique case (state_q)
      S_IDLE: begin
        if (wr_en) begin
          tail_d  = (tail_q == PtrW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
          count_d = count_q + 1'b1;
        end
        if (rd_en) begin
          head_d  = (head_q == PtrW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
          state_d = S_READ;
        end else if (accept) begin
          load   = 1'b1;
          ok_d   = wr_en;
          res_d  = '0;
          pend_d = PendW'(count_d);
        end
      end
      S_READ: begin
        load    = 1'b1;
        ok_d    = 1'b1;
        res_d   = rd_data_q;
        pend_d  = PendW'(count_q);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ok_q   <= ok_d;
      res_q  <= res_d;
      pend_q <= pend_d;
    end
  end

  // event memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= dec_event;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.ok            = ok_q;
  assign out_o.event_code    = res_q.code;
  assign out_o.event_pressed = res_q.pressed;
  assign out_o.event_char    = res_q.chr;
  assign out_o.pending       = pend_q;

endmodule

// ===== hdl/sceq_checker.sv =====
// port-level checker for the scancode event queue and its bind
`include "scancode_event_queue_core_assert.svh"

module sceq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       ok_i,
  input logic [6:0] event_code_i,
  input logic       event_pressed_i,
  input logic [6:0] event_char_i,
  input logic [4:0] pending_i
);

  logic        fields_zero;
  logic [20:0] res_fields;

  assign fields_zero = (event_code_i == '0) && !event_pressed_i && (event_char_i == '0);
  assign res_fields  = {ok_i, event_code_i, event_pressed_i, event_char_i, pending_i};

  `SCEQ_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_i, "result shown in reset")

  `SCEQ_ASSERT(a_fail_fields_zero, out_valid_i && !ok_i |-> fields_zero, "failed result has fields")

  `SCEQ_ASSERT(a_no_accept_past_full_output, in_ready_i && out_valid_i |-> out_ready_i, "input taken")

  `SCEQ_ASSERT(a_stall_holds, out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_fields), "stall")

  `SCEQ_ASSERT(a_result_follows, in_valid_i && in_ready_i |=> ##[0:1] out_valid_i, "no result")

endmodule

bind scancode_event_queue_core sceq_checker u_sceq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .ok_i            (out_o.ok),
  .event_code_i    (out_o.event_code),
  .event_pressed_i (out_o.event_pressed),
  .event_char_i    (out_o.event_char),
  .pending_i       (out_o.pending)
);

// ===== tb/scancode_event_queue_core_tb.sv =====
// self-checking testbench of the scancode event queue: directed table, then random traffic
module scancode_event_queue_core_tb;
  import sceq_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [6:0] code;
    logic       pressed;
    logic [6:0] chr;
    logic [4:0] pending;
  } queue_result_t;

  typedef struct {
    logic          cmd;
    logic [7:0]    raw;
    int unsigned   count;
    logic          typed;
    queue_result_t result;
  } scancode_row_t;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  localparam int unsigned RandomItems = 1050;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned DrainCycles = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  sceq_in_if  in_bus ();
  sceq_out_if out_bus ();

  scancode_event_queue_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  sceq_event_t   held_events [QueueDepth];
  int unsigned   rd_idx;
  int unsigned   wr_idx;
  int unsigned   held_count;
  queue_result_t pending_results [$];
  scancode_row_t scancode_table [$];

  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned stored_count;
  int unsigned dropped_count;
  int unsigned delivered_count;
  int unsigned empty_pop_count;
  int unsigned full_hits;
  int unsigned burst_left;

  queue_result_t seen_result;
  queue_result_t want_result;

  function automatic logic [6:0] key_letter(input logic [6:0] mk);
    string top_row;
    string mid_row;
    string low_row;
    top_row = "QWERTYUIOP";
    mid_row = "ASDFGHJKL";
    low_row = "ZXCVBNM";
    if (mk >= 7'h10 && mk <= 7'h19) return 7'(top_row[mk - 7'h10]);
    if (mk >= 7'h1e && mk <= 7'h26) return 7'(mid_row[mk - 7'h1e]);
    if (mk >= 7'h2c && mk <= 7'h32) return 7'(low_row[mk - 7'h2c]);
    if (mk == 7'h39) return 7'h20;
    return 7'h00;
  endfunction

  function automatic queue_result_t mk_result(input logic ok, input logic [6:0] code,
                                              input logic pressed, input logic [6:0] chr,
                                              input logic [4:0] pending);
    queue_result_t r;
    r.ok      = ok;
    r.code    = code;
    r.pressed = pressed;
    r.chr     = chr;
    r.pending = pending;
    return r;
  endfunction

  function automatic scancode_row_t mk_row(input logic cmd, input logic [7:0] raw,
                                           input int unsigned count, input logic typed,
                                           input queue_result_t result);
    scancode_row_t row;
    row.cmd    = cmd;
    row.raw    = raw;
    row.count  = count;
    row.typed  = typed;
    row.result = result;
    return row;
  endfunction

  task automatic step_event_queue(input logic cmd, input logic [7:0] raw,
                                  output queue_result_t r);
    sceq_event_t ev;
    r = '0;
    if (cmd == CmdPush) begin
      if (raw != PrefixE0 && raw != PrefixE1 && held_count < QueueDepth) begin
        ev.code    = raw[6:0];
        ev.pressed = ~raw[7];
        ev.chr     = key_letter(raw[6:0]);
        held_events[wr_idx] = ev;
        wr_idx = (wr_idx + 1) % QueueDepth;
        held_count++;
        r.ok = 1'b1;
        stored_count++;
        if (held_count == QueueDepth) full_hits++;
      end else begin
        dropped_count++;
      end
    end else begin
      if (held_count != 0) begin
        ev = held_events[rd_idx];
        r.code    = ev.code;
        r.pressed = ev.pressed;
        r.chr     = ev.chr;
        rd_idx = (rd_idx + 1) % QueueDepth;
        held_count--;
        r.ok = 1'b1;
        delivered_count++;
      end else begin
        empty_pop_count++;
      end
    end
    r.pending = 5'(held_count);
  endtask

  // drive one transaction from the falling edge and wait for it to be taken
  task automatic send_scancode(input logic cmd, input logic [7:0] raw,
                               input logic typed, input queue_result_t typed_result);
    queue_result_t predicted;
    in_bus.valid    <= 1'b1;
    in_bus.cmd      <= cmd;
    in_bus.raw_code <= raw;
    do @(posedge clk_i); while (!in_bus.ready);
    step_event_queue(cmd, raw, predicted);
    pending_results.push_back(typed ? typed_result : predicted);
    @(negedge clk_i);
  endtask

  // bursts of random length, random gaps with junk payload in between
  task automatic sender_pause();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_bus.valid    <= 1'b0;
        in_bus.cmd      <= 1'($urandom);
        in_bus.raw_code <= 8'($urandom);
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  function automatic logic [7:0] pick_scancode();
    logic [6:0] mk;
    case ($urandom_range(0, 9))
      0, 1: mk = 7'($urandom_range(16'h10, 16'h19));
      2:    mk = 7'($urandom_range(16'h1e, 16'h26));
      3:    mk = 7'($urandom_range(16'h2c, 16'h32));
      4:    mk = 7'h39;
      5:    return ($urandom_range(0, 1) == 0) ? PrefixE0 : PrefixE1;
      default: return 8'($urandom);
    endcase
    return {1'($urandom), mk};
  endfunction

  // receiver stalls on a pattern that changes mode from time to time
  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned phase;
    out_bus.ready = 1'b0;
    mode      = RX_ALWAYS;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      phase++;
      case (mode)
        RX_ALWAYS:   out_bus.ready <= 1'b1;
        RX_RANDOM:   out_bus.ready <= 1'($urandom);
        RX_SPARSE:   out_bus.ready <= ($urandom_range(0, 3) == 0);
        default:     out_bus.ready <= (phase % 5) < 2;
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      seen_result = mk_result(out_bus.ok, out_bus.event_code, out_bus.event_pressed,
                              out_bus.event_char, out_bus.pending);
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("result with nothing outstanding: ok=%0d code=%h pressed=%0d chr=%h pend=%0d",
                   seen_result.ok, seen_result.code, seen_result.pressed, seen_result.chr,
                   seen_result.pending);
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result !== want_result) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("mismatch at result %0d: exp ok=%0d code=%h pressed=%0d chr=%h pend=%0d, got ok=%0d code=%h pressed=%0d chr=%h pend=%0d",
                     result_count, want_result.ok, want_result.code, want_result.pressed,
                     want_result.chr, want_result.pending, seen_result.ok, seen_result.code,
                     seen_result.pressed, seen_result.chr, seen_result.pending);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned   sent;
    int unsigned   phase_left;
    int unsigned   push_pct;
    logic [7:0]    raw;
    queue_result_t none;
    none = '0;

    rst_ni          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.cmd      = CmdPush;
    in_bus.raw_code = 8'h00;
    rd_idx          = 0;
    wr_idx          = 0;
    held_count      = 0;
    burst_left      = 1;
    for (int i = 0; i < QueueDepth; i++) held_events[i] = '0;

    scancode_table.push_back(mk_row(CmdPop,  8'h00,    1, 1'b1, mk_result(0, 0, 0, 0, 0)));
    scancode_table.push_back(mk_row(CmdPush, PrefixE0, 1, 1'b1, mk_result(0, 0, 0, 0, 0)));
    scancode_table.push_back(mk_row(CmdPush, PrefixE1, 1, 1'b1, mk_result(0, 0, 0, 0, 0)));
    scancode_table.push_back(mk_row(CmdPop,  8'hff,    1, 1'b1, mk_result(0, 0, 0, 0, 0)));
    scancode_table.push_back(mk_row(CmdPush, 8'h00,    1, 1'b1, mk_result(1, 0, 0, 0, 1)));
    scancode_table.push_back(mk_row(CmdPush, 8'hff,    1, 1'b1, mk_result(1, 0, 0, 0, 2)));
    scancode_table.push_back(mk_row(CmdPush, 8'h10,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'h99,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'h1e,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'ha6,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'h2c,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'hb2,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'h39,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'hb9,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'h1d,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'h61,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'h7f,    4, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPush, 8'h20,    1, 1'b1, mk_result(0, 0, 0, 0, 16)));
    scancode_table.push_back(mk_row(CmdPush, PrefixE0, 1, 1'b1, mk_result(0, 0, 0, 0, 16)));
    scancode_table.push_back(mk_row(CmdPop,  8'h55,   16, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPop,  8'h00,    1, 1'b1, mk_result(0, 0, 0, 0, 0)));
    scancode_table.push_back(mk_row(CmdPush, 8'h80,    1, 1'b0, none));
    scancode_table.push_back(mk_row(CmdPop,  8'h00,    1, 1'b0, none));

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (scancode_table[i]) begin
      for (int n = 0; n < scancode_table[i].count; n++) begin
        send_scancode(scancode_table[i].cmd, scancode_table[i].raw,
                      scancode_table[i].typed, scancode_table[i].result);
        sender_pause();
      end
    end

    // phases with a varying push share, so the queue runs both full and empty often
    sent       = 0;
    phase_left = 0;
    push_pct   = 50;
    while (sent < RandomItems) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 80;
          default: push_pct = 95;
        endcase
        phase_left = $urandom_range(30, 90);
      end
      phase_left--;
      if ($urandom_range(1, 100) <= push_pct) begin
        raw = pick_scancode();
        if ($urandom_range(0, 9) == 0) begin
          // extended key: prefix byte then the code
          send_scancode(CmdPush, ($urandom_range(0, 1) == 0) ? PrefixE0 : PrefixE1, 1'b0, none);
          sender_pause();
          sent++;
        end
        send_scancode(CmdPush, raw, 1'b0, none);
      end else begin
        send_scancode(CmdPop, 8'($urandom), 1'b0, none);
      end
      sender_pause();
      sent++;
    end
    in_bus.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d results: %0d events stored, %0d pushes dropped, queue full %0d times",
             result_count, stored_count, dropped_count, full_hits);
    $display("%0d events delivered, %0d pops on an empty queue, %0d mismatches",
             delivered_count, empty_pop_count, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
